// ===== hdl/mnmp_pkg.sv =====
// Package: shared types and constants for the MIDI note message parser.
package mnmp_pkg;

  localparam int BYTE_W  = 8;
  localparam int DATA7_W = 7;
  localparam int CHAN_W  = 4;
  localparam int OUT_W   = 16;

  localparam logic [BYTE_W-1:0] REALTIME_MIN = 8'hF8;
  localparam logic [3:0]        KIND_NOTE_ON  = 4'h9;
  localparam logic [3:0]        KIND_NOTE_OFF = 4'h8;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_NOTE = 2'd1,
    PH_VEL  = 2'd2
  } phase_t;

  typedef struct packed {
    logic                 is_note_on;
    logic [DATA7_W-1:0]   note_number;
    logic [DATA7_W-1:0]   note_velocity;
  } note_evt_t;

endpackage

// ===== hdl/midi_note_message_parser_top.sv =====
// Top level: MIDI note-on/note-off parser with running status and channel filter.
//
// Takes one received MIDI byte per transfer on in_* and emits a note event on out_* when a
// complete note-on or note-off message on the configured channel has been collected.
// Real-time bytes (0xF8 and up) are ignored, running status is supported, and a note-on with
// velocity zero is reported as a note-off. A byte is accepted in every cycle; each byte passes
// through an input register and, if it completes a message, a result register that drives out_*.
// While an event waits on out_tready the input register holds the next byte and in_tready drops
// only if that byte would also emit.
// cfg_data sets the listen channel; write it only while the parser is idle.
module midi_note_message_parser_top
  import mnmp_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CHAN_W-1:0]   cfg_data,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [BYTE_W-1:0]   in_tdata,   // [7:0] rx_byte
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [OUT_W-1:0]    out_tdata   // [0] is_note_on, [7:1] note_number,
                                          // [14:8] note_velocity, [15] zero
);

  logic [CHAN_W-1:0]  listen_r;
  logic               in_valid_r;
  logic [BYTE_W-1:0]  in_byte_r;
  phase_t             phase_r, phase_nxt;
  logic [BYTE_W-1:0]  rs_r, rs_nxt;
  logic [DATA7_W-1:0] held_r, held_nxt;
  logic               out_valid_r;
  note_evt_t          evt_r, evt_nxt;
  logic               emit;
  logic               rs_valid;
  logic               out_free;
  logic               stage_go;

  assign cfg_ready = 1'b1;
  assign rs_valid  = (rs_r[7:4] == KIND_NOTE_ON) || (rs_r[7:4] == KIND_NOTE_OFF);
  assign out_free  = !out_valid_r || out_tready;
  assign stage_go  = in_valid_r && (!emit || out_free);
  assign in_tready = !in_valid_r || stage_go;

  // next parse state
  always_comb begin
    phase_nxt = phase_r;
    rs_nxt    = rs_r;
    held_nxt  = held_r;
    if (in_byte_r >= REALTIME_MIN) begin
      phase_nxt = phase_r;
    end else if (in_byte_r[7]) begin
      if ((in_byte_r[7:4] == KIND_NOTE_ON) || (in_byte_r[7:4] == KIND_NOTE_OFF)) begin
        rs_nxt    = in_byte_r;
        phase_nxt = PH_NOTE;
      end else begin
        rs_nxt    = '0;
        phase_nxt = PH_IDLE;
      end
    end else begin
      case (phase_r)
        PH_NOTE: begin
          held_nxt  = in_byte_r[DATA7_W-1:0];
          phase_nxt = PH_VEL;
        end
        PH_VEL: begin
          phase_nxt = PH_IDLE;
        end
        default: begin
          if (rs_valid) begin
            held_nxt  = in_byte_r[DATA7_W-1:0];
            phase_nxt = PH_VEL;
          end else begin
            phase_nxt = PH_IDLE;
          end
        end
      endcase
    end
  end

  // event decode
  always_comb begin
    emit                  = 1'b0;
    evt_nxt.note_number   = held_r;
    evt_nxt.note_velocity = in_byte_r[DATA7_W-1:0];
    evt_nxt.is_note_on    = (rs_r[7:4] == KIND_NOTE_ON) && (in_byte_r[DATA7_W-1:0] != '0);
    if (!in_byte_r[7] && (phase_r == PH_VEL) && rs_valid && (rs_r[3:0] == listen_r)) begin
      emit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      listen_r    <= '0;
      in_valid_r  <= 1'b0;
      phase_r     <= PH_IDLE;
      rs_r        <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        listen_r <= cfg_data;
      end
      if (in_tready) begin
        in_valid_r <= in_tvalid;
      end
      if (stage_go) begin
        phase_r <= phase_nxt;
        rs_r    <= rs_nxt;
        held_r  <= held_nxt;
      end
      if (stage_go && emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
    end
    if (stage_go && emit) begin
      evt_r <= evt_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, evt_r.note_velocity, evt_r.note_number, evt_r.is_note_on};

endmodule

// ===== hdl/mnmp_checker.sv =====
// Checker: port-level assertions for the MIDI note message parser, bound to the top level.
module mnmp_checker
  import mnmp_pkg::*;
(
  input logic              clk,
  input logic              rst_n,
  input logic              cfg_valid,
  input logic              cfg_ready,
  input logic [CHAN_W-1:0] cfg_data,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic [BYTE_W-1:0] in_tdata,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_W-1:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[15])
    else $error("pad bit set");

  a_on_vel: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[0] |-> out_tdata[14:8] != 7'd0)
    else $error("note-on with zero velocity");

  a_rst_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(out_tvalid) && !$past(in_tvalid) && !$past(in_tvalid, 2) && $past(rst_n, 2)
      |-> !out_tvalid)
    else $error("result without input transfer");

endmodule

bind midi_note_message_parser_top mnmp_checker u_mnmp_checker (.*);

// ===== verif/tb_top.sv =====
// Testbench for the MIDI note message parser: random and directed byte streams, event check.
`timescale 1ns / 1ps

class note_event_tracker;
  logic [mnmp_pkg::CHAN_W-1:0]  listen_ch;
  mnmp_pkg::phase_t             phase;
  logic [mnmp_pkg::BYTE_W-1:0]  run_status;
  logic [mnmp_pkg::DATA7_W-1:0] held_note;
  mnmp_pkg::note_evt_t          due_events[$];
  int                           errors;

  function new();
    listen_ch  = '0;
    phase      = mnmp_pkg::PH_IDLE;
    run_status = '0;
    held_note  = '0;
    errors     = 0;
  endfunction

  function bit has_running();
    return run_status[7:4] == mnmp_pkg::KIND_NOTE_ON ||
           run_status[7:4] == mnmp_pkg::KIND_NOTE_OFF;
  endfunction

  // Advances the parse by one accepted byte; queues the event it completes, if any.
  function void take_byte(logic [mnmp_pkg::BYTE_W-1:0] b);
    mnmp_pkg::note_evt_t ev;
    bit rs_ok;
    rs_ok = has_running();
    if (b >= mnmp_pkg::REALTIME_MIN) return;
    if (b[7]) begin
      if (b[7:4] == mnmp_pkg::KIND_NOTE_ON || b[7:4] == mnmp_pkg::KIND_NOTE_OFF) begin
        run_status = b;
        phase = mnmp_pkg::PH_NOTE;
      end else begin
        run_status = '0;
        phase = mnmp_pkg::PH_IDLE;
      end
      return;
    end
    case (phase)
      mnmp_pkg::PH_NOTE: begin
        held_note = b[6:0];
        phase = mnmp_pkg::PH_VEL;
      end
      mnmp_pkg::PH_VEL: begin
        phase = mnmp_pkg::PH_IDLE;
        if (rs_ok && run_status[3:0] == listen_ch) begin
          ev.is_note_on    = (run_status[7:4] == mnmp_pkg::KIND_NOTE_ON) && (b != 0);
          ev.note_number   = held_note;
          ev.note_velocity = b[6:0];
          due_events.push_back(ev);
        end
      end
      default: begin
        phase = mnmp_pkg::PH_IDLE;
        if (rs_ok) begin
          held_note = b[6:0];
          phase = mnmp_pkg::PH_VEL;
        end
      end
    endcase
  endfunction

  function void cmp_field(string fname, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, exp_v, act_v);
      errors++;
    end
  endfunction

  function void check_event(logic [mnmp_pkg::OUT_W-1:0] d);
    mnmp_pkg::note_evt_t ev;
    if (due_events.size() == 0) begin
      $display("%0t: unexpected event, expected none, actual 0x%04h", $time, d);
      errors++;
      return;
    end
    ev = due_events.pop_front();
    cmp_field("is_note_on", ev.is_note_on, d[0]);
    cmp_field("note_number", ev.note_number, d[7:1]);
    cmp_field("note_velocity", ev.note_velocity, d[14:8]);
    cmp_field("pad", 0, d[15]);
  endfunction
endclass

module tb_top;
  import mnmp_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 8;
  localparam int PHASE_ITEMS    = 80;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CHAN_W-1:0] cfg_data = '0;
  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [BYTE_W-1:0] in_tdata = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [OUT_W-1:0]  out_tdata;

  note_event_tracker tracker = new();
  bit                gaps_on = 1'b1;
  bit                stalls_on = 1'b1;
  int                stall_left = 0;
  int                idle_cycles = 0;
  int                items_sent = 0;

  midi_note_message_parser_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Result side: random backpressure while stalls_on is set, checks each transfer.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_event(out_tdata);
    if (!stalls_on) begin
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else begin
      stall_left <= pick_gap();
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired", $time);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_byte(logic [BYTE_W-1:0] b);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    tracker.take_byte(b);
    if (b < REALTIME_MIN) items_sent++;
  endtask

  // Occasionally slips a real-time byte in front of the byte.
  task automatic send_mixed(logic [BYTE_W-1:0] b);
    if ($urandom_range(0, 9) == 0) send_byte(8'($urandom_range(int'(REALTIME_MIN), 255)));
    send_byte(b);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (tracker.due_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_channel(logic [CHAN_W-1:0] ch);
    cfg_valid <= 1'b1;
    cfg_data  <= ch;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    tracker.listen_ch = ch;
  endtask

  task automatic send_random_message();
    int                r;
    logic [CHAN_W-1:0] ch;
    logic [3:0]        kind;
    r = $urandom_range(0, 99);
    kind = $urandom_range(0, 1) ? KIND_NOTE_ON : KIND_NOTE_OFF;
    ch = ($urandom_range(0, 9) < 6) ? tracker.listen_ch : 4'($urandom_range(0, 15));
    if (r < 72) begin
      if (!tracker.has_running() || $urandom_range(0, 2) == 0) send_mixed({kind, ch});
      send_mixed(8'($urandom_range(0, 127)));
      send_mixed(($urandom_range(0, 6) == 0) ? 8'h00 : 8'($urandom_range(0, 127)));
    end else if (r < 86) begin
      send_mixed(8'($urandom_range(0, 255)));
    end else begin
      send_mixed({kind, ch});
      if ($urandom_range(0, 1)) send_mixed(8'($urandom_range(0, 127)));
      send_mixed(8'($urandom_range(8'h80, 8'hF7)));
    end
  endtask

  initial begin
    logic [BYTE_W-1:0] directed[] = '{
      8'h00, 8'h7F,
      8'h90, 8'h00, 8'h7F,
      8'h7F, 8'h00,
      8'h80, 8'h40, 8'hF8, 8'h40,
      8'h90, 8'h3C, 8'h80, 8'h10, 8'h20,
      8'h93, 8'h11, 8'h22,
      8'hB0, 8'h01, 8'h02,
      8'hFF, 8'hF0, 8'h05
    };
    logic [CHAN_W-1:0] phase_ch[] = '{4'hF, 4'h0, 4'h7, 4'hA, 4'h3};
    int target;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_channel(4'h0);
    foreach (directed[i]) send_byte(directed[i]);

    foreach (phase_ch[p]) begin
      wait_drained();
      write_channel(p >= 3 ? 4'($urandom_range(0, 15)) : phase_ch[p]);
      gaps_on   = (p != 1);
      stalls_on = (p != 2);
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        send_random_message();
        if (p == 3 && items_sent >= target - PHASE_ITEMS / 2 &&
            tracker.due_events.size() != 0) begin
          in_tvalid <= 1'b0;
          while (tracker.due_events.size() != 0) @(posedge clk);
        end
      end
    end

    wait_drained();
    if (tracker.errors == 0 && tracker.due_events.size() == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
